// File: hdl/asd_pkg.sv
// Shared types, constants and register codes for the accelerometer step detector.
package asd_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF = 8;
  localparam int COUNT_BITS_DEF = 24;

  localparam int THRESH_BITS = 11;
  localparam int DEBOUNCE_BITS = 16;
  localparam int OFFSET_BITS = 11;
  localparam int COEF_BITS = 8;
  localparam int COEF_SHIFT = 8;
  localparam int TIME_BITS = 32;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SMOOTHING = 2'd3;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 11'd600;
  localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 16'd250;
  localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 11'd1000;
  localparam logic [COEF_BITS-1:0] COEF_RESET = 8'd26;

  typedef struct packed {
    logic [THRESH_BITS-1:0] threshold;
    logic [DEBOUNCE_BITS-1:0] debounce;
    logic [OFFSET_BITS-1:0] offset;
    logic [COEF_BITS-1:0] coef;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_MULT,
    ST_UPDATE
  } state_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    logic load;
    logic square;
    axis_t axis;
    logic root_step;
    logic mult;
    logic commit;
  } cmd_t;

endpackage

// File: hdl/asd_cfg_regs.sv
// Configuration register file of the step detector.
module asd_cfg_regs (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [asd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [asd_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output asd_pkg::cfg_t cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= asd_pkg::THRESH_RESET;
      cfg.debounce <= asd_pkg::DEBOUNCE_RESET;
      cfg.offset <= asd_pkg::OFFSET_RESET;
      cfg.coef <= asd_pkg::COEF_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        asd_pkg::REG_THRESHOLD: cfg.threshold <= cfg_data[asd_pkg::THRESH_BITS-1:0];
        asd_pkg::REG_DEBOUNCE: cfg.debounce <= cfg_data[asd_pkg::DEBOUNCE_BITS-1:0];
        asd_pkg::REG_OFFSET: cfg.offset <= cfg_data[asd_pkg::OFFSET_BITS-1:0];
        asd_pkg::REG_SMOOTHING: cfg.coef <= cfg_data[asd_pkg::COEF_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hdl/asd_ctrl.sv
// Sequencing state machine of the step detector.
module asd_ctrl #(
  parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic sample_valid,
  output logic sample_stall,
  output logic result_valid,
  input  logic result_stall,
  output asd_pkg::cmd_t cmd
);

  localparam int CNT_BITS = $clog2(SAMPLE_BITS);
  localparam logic [CNT_BITS-1:0] LAST_ROOT = CNT_BITS'(SAMPLE_BITS - 1);
  localparam logic [CNT_BITS-1:0] LAST_SQUARE = CNT_BITS'(asd_pkg::AXIS_Z);

  asd_pkg::state_t state, state_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;
  logic slot_free;

  assign slot_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= asd_pkg::ST_IDLE;
      cnt <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (cmd.commit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    case (state)
      asd_pkg::ST_IDLE: begin
        cnt_next = '0;
        if (sample_valid) begin
          state_next = asd_pkg::ST_SQUARE;
        end
      end
      asd_pkg::ST_SQUARE: begin
        if (cnt == LAST_SQUARE) begin
          state_next = asd_pkg::ST_ROOT;
          cnt_next = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      asd_pkg::ST_ROOT: begin
        if (cnt == LAST_ROOT) begin
          state_next = asd_pkg::ST_MULT;
          cnt_next = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      asd_pkg::ST_MULT: begin
        state_next = asd_pkg::ST_UPDATE;
      end
      asd_pkg::ST_UPDATE: begin
        if (slot_free) begin
          state_next = asd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = asd_pkg::ST_IDLE;
        cnt_next = '0;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.axis = asd_pkg::axis_t'(cnt[1:0]);
    sample_stall = 1'b1;
    case (state)
      asd_pkg::ST_IDLE: begin
        sample_stall = 1'b0;
        cmd.load = sample_valid;
      end
      asd_pkg::ST_SQUARE: cmd.square = 1'b1;
      asd_pkg::ST_ROOT: cmd.root_step = 1'b1;
      asd_pkg::ST_MULT: cmd.mult = 1'b1;
      asd_pkg::ST_UPDATE: cmd.commit = slot_free;
      default: begin
      end
    endcase
  end

  a_commit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!result_valid || !result_stall))
    else $error("Result published over a transaction still waiting.");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result_valid)
    else $error("Published result is not presented.");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> (state == asd_pkg::ST_SQUARE && cnt == '0))
    else $error("Accepted transaction did not start the squaring phase.");

  a_root_length: assert property (@(posedge clk) disable iff (rst)
    (state == asd_pkg::ST_ROOT && cnt == LAST_ROOT) |=> state == asd_pkg::ST_MULT)
    else $error("Square root phase did not end after its last bit.");

endmodule

// File: hdl/asd_datapath.sv
// Datapath of the step detector: squares, square root, low-pass filter and step counter.
module asd_datapath #(
  parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS = asd_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = asd_pkg::COUNT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  asd_pkg::cmd_t cmd,
  input  asd_pkg::cfg_t cfg,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_y,
  input  logic signed [SAMPLE_BITS-1:0] accel_z,
  input  logic [asd_pkg::TIME_BITS-1:0] timestamp_ms,
  output logic [SAMPLE_BITS-1:0] magnitude_mg,
  output logic signed [SAMPLE_BITS:0] filtered_mg,
  output logic step_detected,
  output logic [COUNT_BITS-1:0] step_total
);

  localparam int S = SAMPLE_BITS;
  localparam int LEVEL_BITS = SAMPLE_BITS + 1 + FRAC_BITS;
  localparam int MO_BITS =
    (SAMPLE_BITS > asd_pkg::OFFSET_BITS ? SAMPLE_BITS : asd_pkg::OFFSET_BITS) + 1;
  localparam int TGT_BITS = MO_BITS + FRAC_BITS;
  localparam int DIFF_BITS = (TGT_BITS > LEVEL_BITS ? TGT_BITS : LEVEL_BITS) + 1;
  localparam int PROD_BITS = DIFF_BITS + asd_pkg::COEF_BITS + 1;
  localparam int SUM_BITS = PROD_BITS - asd_pkg::COEF_SHIFT + 1;
  localparam int THR_BITS = asd_pkg::THRESH_BITS + FRAC_BITS + 1;
  localparam int CMP_BITS = (LEVEL_BITS > THR_BITS ? LEVEL_BITS : THR_BITS) + 1;

  logic signed [S-1:0] ax, ay, az;
  logic [asd_pkg::TIME_BITS-1:0] now;
  logic [2*S-1:0] acc;
  logic [S-1:0] root;
  logic [S:0] rem;
  logic signed [PROD_BITS-1:0] prod;
  logic signed [LEVEL_BITS-1:0] level;
  logic [asd_pkg::TIME_BITS-1:0] last_step_time;
  logic [COUNT_BITS-1:0] step_counter;

  logic signed [S-1:0] sel;
  logic signed [2*S-1:0] sq;
  logic [S+1:0] rem_shift, trial;
  logic fits;
  logic signed [MO_BITS-1:0] mag_ofs;
  logic signed [TGT_BITS-1:0] tgt;
  logic signed [DIFF_BITS-1:0] diff;
  logic signed [PROD_BITS-1:0] step_part;
  logic signed [SUM_BITS-1:0] lvl_wide;
  logic signed [LEVEL_BITS-1:0] lvl;
  logic overflow;
  logic signed [CMP_BITS-1:0] thr;
  logic above, debounced, det;
  logic [asd_pkg::TIME_BITS-1:0] elapsed;
  logic [COUNT_BITS-1:0] step_counter_next;

  always_comb begin
    case (cmd.axis)
      asd_pkg::AXIS_X: sel = ax;
      asd_pkg::AXIS_Y: sel = ay;
      asd_pkg::AXIS_Z: sel = az;
      default: sel = ax;
    endcase
  end

  assign sq = (2*S)'(sel) * (2*S)'(sel);

  // One result bit per cycle; the radicand is shifted out two bits at a time.
  assign rem_shift = {rem[S-1:0], acc[2*S-1:2*S-2]};
  assign trial = {root, 2'b01};
  assign fits = rem_shift >= trial;

  assign mag_ofs = signed'(MO_BITS'(root)) - signed'(MO_BITS'(cfg.offset));
  assign tgt = signed'({mag_ofs, {FRAC_BITS{1'b0}}});
  assign diff = DIFF_BITS'(tgt) - DIFF_BITS'(level);

  assign step_part = prod >>> asd_pkg::COEF_SHIFT;
  assign lvl_wide = SUM_BITS'(step_part) + SUM_BITS'(level);
  assign overflow = !((&lvl_wide[SUM_BITS-1:LEVEL_BITS-1]) ||
                      !(|lvl_wide[SUM_BITS-1:LEVEL_BITS-1]));

  always_comb begin
    if (!overflow) begin
      lvl = lvl_wide[LEVEL_BITS-1:0];
    end else if (lvl_wide[SUM_BITS-1]) begin
      lvl = {1'b1, {(LEVEL_BITS-1){1'b0}}};
    end else begin
      lvl = {1'b0, {(LEVEL_BITS-1){1'b1}}};
    end
  end

  assign thr = signed'(CMP_BITS'({cfg.threshold, {FRAC_BITS{1'b0}}}));
  assign above = CMP_BITS'(lvl) > thr;
  assign elapsed = now - last_step_time;
  assign debounced = elapsed > asd_pkg::TIME_BITS'(cfg.debounce);
  assign det = above && debounced;
  assign step_counter_next = (det && step_counter != '1) ? step_counter + 1'b1 : step_counter;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax <= accel_x;
      ay <= accel_y;
      az <= accel_z;
      now <= timestamp_ms;
      acc <= '0;
      root <= '0;
      rem <= '0;
    end else if (cmd.square) begin
      acc <= acc + $unsigned(sq);
    end else if (cmd.root_step) begin
      acc <= {acc[2*S-3:0], 2'b00};
      root <= {root[S-2:0], fits};
      rem <= fits ? (S+1)'(rem_shift - trial) : rem_shift[S:0];
    end
    if (cmd.mult) begin
      prod <= PROD_BITS'(diff) * PROD_BITS'(signed'({1'b0, cfg.coef}));
    end
    if (cmd.commit) begin
      magnitude_mg <= root;
      filtered_mg <= lvl[LEVEL_BITS-1:FRAC_BITS];
      step_detected <= det;
      step_total <= step_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      last_step_time <= '0;
      step_counter <= '0;
    end else if (cmd.commit) begin
      level <= lvl;
      step_counter <= step_counter_next;
      if (det) begin
        last_step_time <= now;
      end
    end
  end

endmodule

// File: hdl/accel_step_detector.sv
// Top level of the accelerometer step detector.
// Each accepted transaction runs through these steps before another can be accepted:
// capture the sample, square and sum the axes on a single shared multiplier, compute one
// result bit per cycle in the restoring square-root unit, perform the filter multiplication
// and update the level and the step count. That last step waits while the previous result
// is still held on the output. Configuration writes take effect at once and should only be
// made while no transaction is in progress.
module accel_step_detector #(
  parameter int SAMPLE_BITS = asd_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS = asd_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = asd_pkg::COUNT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [asd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [asd_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic sample_valid,
  output logic sample_stall,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_y,
  input  logic signed [SAMPLE_BITS-1:0] accel_z,
  input  logic [asd_pkg::TIME_BITS-1:0] timestamp_ms,
  output logic result_valid,
  input  logic result_stall,
  output logic [SAMPLE_BITS-1:0] magnitude_mg,
  output logic signed [SAMPLE_BITS:0] filtered_mg,
  output logic step_detected,
  output logic [COUNT_BITS-1:0] step_total
);

  asd_pkg::cfg_t cfg;
  asd_pkg::cmd_t cmd;

  asd_cfg_regs u_cfg_regs (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg)
  );

  asd_ctrl #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .cmd(cmd)
  );

  asd_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS(FRAC_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .cfg(cfg),
    .accel_x(accel_x),
    .accel_y(accel_y),
    .accel_z(accel_z),
    .timestamp_ms(timestamp_ms),
    .magnitude_mg(magnitude_mg),
    .filtered_mg(filtered_mg),
    .step_detected(step_detected),
    .step_total(step_total)
  );

endmodule
